// ===== rtl/bia_pkg.sv =====
package bia_pkg;

  // Field widths of the request and response beats.
  localparam int OPCODE_W  = 2;
  localparam int ID_W      = 12;
  localparam int STATUS_W  = 2;
  localparam int LIMIT_W   = 13;
  localparam int CFG_IDX_W = 1;

  // Request opcodes. The fourth code is unused and answered as invalid.
  localparam logic [OPCODE_W-1:0] OP_ALLOC       = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC_AFTER = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE        = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STS_INVALID = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INODE_LIMIT = 1'b1;

  // Both limits come out of reset at this value.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

endpackage

// ===== rtl/bia_req_if.sv =====
interface bia_req_if;
  import bia_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                map_select;
  logic [ID_W-1:0]     target_id;

  modport source (output valid, output opcode, output map_select, output target_id,
                  input ready);
  modport sink   (input valid, input opcode, input map_select, input target_id,
                  output ready);
endinterface

// ===== rtl/bia_rsp_if.sv =====
interface bia_rsp_if;
  import bia_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     result_id;

  modport source (output valid, output status, output result_id, input ready);
  modport sink   (input valid, input status, input result_id, output ready);
endinterface

// ===== rtl/bia_map_ram.sv =====
module bia_map_ram #(
  parameter int AW = 7,
  parameter int DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  output logic          busy_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;
  logic [AW-1:0] clr_q;
  logic          busy_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;

  // After reset the sweep owns the write port and zeroes one word a cycle.
  assign mem_we = busy_q | we_i;
  assign mem_wa = busy_q ? clr_q : waddr_i;
  assign mem_wd = busy_q ? '0 : wdata_i;

  // Clearing sweep over every word of both maps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == {AW{1'b1}}) begin
        busy_q <= 1'b0;
      end
    end
  end

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

// ===== rtl/bitmap_id_allocator_top.sv =====
// Channel   Dir  Handshake      Beat contents
// req_i     in   valid/ready    opcode, map_select, target_id
// rsp_o     out  valid/ready    status, result_id
// cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i (block or inode limit)
//
// One request is worked on at a time. An allocate walks the map one word per
// cycle through the RAM read port, then shifts the first word with a free bit
// out one bit per cycle; an allocate-after that finds nothing at or after its
// target id walks the map again from id zero. A free walks words up to the
// target word.
// After reset both maps are zeroed one word a cycle, with req_i.ready low.
// A finished response waits in the output register while the next request is
// taken; a stalled rsp_o holds back only the following response.
module bitmap_id_allocator_top #(
  parameter int MAP_BITS  = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bia_req_if.sink                      req_i,
  bia_rsp_if.source                    rsp_o,
  input  logic                         cfg_we_i,
  input  logic [bia_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bia_pkg::LIMIT_W-1:0]  cfg_wdata_i
);
  import bia_pkg::*;

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int AW        = WAW + 1;
  localparam int CW_RAW    = $clog2(MAP_BITS + WORD_BITS + 1);
  localparam int CW        = (CW_RAW > LIMIT_W) ? CW_RAW : LIMIT_W;
  localparam int OW        = $clog2(WORD_BITS + 1);
  localparam int BW        = $clog2(WORD_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_BITS,
    S_RESP
  } state_e;

  state_e               state_q;
  logic [LIMIT_W-1:0]   blk_lim_q;
  logic [LIMIT_W-1:0]   ino_lim_q;
  logic [OPCODE_W-1:0]  op_q;
  logic                 sel_q;
  logic [CW-1:0]        from_q;
  logic [CW-1:0]        lim_q;
  logic                 fb_q;
  logic [WAW-1:0]       ra_q;
  logic                 dv_q;
  logic [CW-1:0]        base_q;
  logic [WAW-1:0]       wa_q;
  logic [CW-1:0]        wbase_q;
  logic [WORD_BITS-1:0] sh_q;
  logic [WORD_BITS-1:0] word_q;
  logic [BW-1:0]        bc_q;
  logic [STATUS_W-1:0]  res_st_q;
  logic [ID_W-1:0]      res_id_q;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_st_q;
  logic [ID_W-1:0]      out_id_q;

  logic                 acc;
  logic                 ram_busy;
  logic [LIMIT_W-1:0]   sel_lim;
  logic [CW-1:0]        lim_new;
  logic [CW-1:0]        from_rel;
  logic [CW-1:0]        hi_rel;
  logic [OW-1:0]        lo_off;
  logic [OW-1:0]        hi_off;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] avail;
  logic                 past_lim;
  logic                 free_hit;
  logic                 tgt_bit;
  logic [CW-1:0]        found_id;
  logic                 mem_we;
  logic [WAW-1:0]       mem_word;
  logic [AW-1:0]        mem_wa;
  logic [AW-1:0]        mem_ra;
  logic [WORD_BITS-1:0] mem_wd;
  logic [WORD_BITS-1:0] one_word;

  // Handshakes and output register.
  assign acc             = req_i.valid && req_i.ready;
  assign req_i.ready     = (state_q == S_IDLE) && !ram_busy;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_st_q;
  assign rsp_o.result_id = out_id_q;

  // Effective limit of the selected map, capped at the map size.
  assign sel_lim = req_i.map_select ? ino_lim_q : blk_lim_q;
  assign lim_new = (CW'(sel_lim) > CW'(MAP_BITS)) ? CW'(MAP_BITS) : CW'(sel_lim);

  // Window of ids inside the current word: at or above the start, below the limit.
  assign from_rel = from_q - base_q;
  assign hi_rel   = lim_q - base_q;
  assign lo_off   = (from_q <= base_q) ? '0 :
                    (from_rel >= CW'(WORD_BITS)) ? OW'(WORD_BITS) : from_rel[OW-1:0];
  assign hi_off   = (hi_rel >= CW'(WORD_BITS)) ? OW'(WORD_BITS) : hi_rel[OW-1:0];
  assign lo_mask  = {WORD_BITS{1'b1}} << lo_off;
  assign hi_mask  = ~({WORD_BITS{1'b1}} << hi_off);
  assign avail    = ~rdata & lo_mask & hi_mask;
  assign past_lim = base_q >= lim_q;

  // For a free, the start register holds the target id.
  assign free_hit = from_rel < CW'(WORD_BITS);
  assign tgt_bit  = rdata[from_rel[BW-1:0]];
  assign found_id = wbase_q + CW'(bc_q);
  assign one_word = {{(WORD_BITS-1){1'b0}}, 1'b1};

  // RAM port control: the read address runs one word ahead of the data.
  assign mem_ra   = {sel_q, ra_q};
  assign mem_word = (state_q == S_BITS) ? wa_q : ra_q - 1'b1;
  assign mem_wa   = {sel_q, mem_word};
  assign mem_we   = ((state_q == S_BITS) && sh_q[0]) ||
                    ((state_q == S_SCAN) && dv_q && !past_lim && (op_q == OP_FREE) &&
                     free_hit && tgt_bit);
  assign mem_wd   = (state_q == S_BITS) ? (word_q | (one_word << bc_q)) :
                    (rdata & ~(one_word << from_rel[BW-1:0]));

  bia_map_ram #(
    .AW (AW),
    .DW (WORD_BITS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (rdata),
    .busy_o  (ram_busy)
  );

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_lim_q <= LIMIT_RESET;
      ino_lim_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_LIMIT: blk_lim_q <= cfg_wdata_i;
        CFG_INODE_LIMIT: ino_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Request sequencer: word walk, bit shift-out and response hand-off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ALLOC;
      sel_q       <= 1'b0;
      from_q      <= '0;
      lim_q       <= '0;
      fb_q        <= 1'b0;
      ra_q        <= '0;
      dv_q        <= 1'b0;
      base_q      <= '0;
      wa_q        <= '0;
      wbase_q     <= '0;
      sh_q        <= '0;
      word_q      <= '0;
      bc_q        <= '0;
      res_st_q    <= STS_OK;
      res_id_q    <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= STS_OK;
      out_id_q    <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            op_q     <= req_i.opcode;
            sel_q    <= req_i.map_select;
            lim_q    <= lim_new;
            fb_q     <= 1'b0;
            ra_q     <= '0;
            dv_q     <= 1'b0;
            base_q   <= '0;
            res_id_q <= '0;
            from_q   <= (req_i.opcode == OP_ALLOC) ? '0 : CW'(req_i.target_id);
            case (req_i.opcode)
              OP_ALLOC, OP_ALLOC_AFTER: begin
                state_q <= S_SCAN;
              end
              OP_FREE: begin
                if (CW'(req_i.target_id) >= lim_new) begin
                  res_st_q <= STS_INVALID;
                  state_q  <= S_RESP;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              default: begin
                res_st_q <= STS_INVALID;
                state_q  <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          ra_q <= ra_q + 1'b1;
          dv_q <= 1'b1;
          if (dv_q) begin
            if (past_lim) begin
              if ((op_q == OP_ALLOC_AFTER) && !fb_q) begin
                // Nothing at or after the start: retry from id zero.
                fb_q   <= 1'b1;
                from_q <= '0;
                ra_q   <= '0;
                dv_q   <= 1'b0;
                base_q <= '0;
              end else begin
                res_st_q <= (op_q == OP_FREE) ? STS_INVALID : STS_NOSPACE;
                state_q  <= S_RESP;
              end
            end else if (op_q == OP_FREE) begin
              if (free_hit) begin
                res_st_q <= tgt_bit ? STS_OK : STS_INVALID;
                state_q  <= S_RESP;
              end else begin
                base_q <= base_q + CW'(WORD_BITS);
              end
            end else if (|avail) begin
              sh_q    <= avail;
              word_q  <= rdata;
              wbase_q <= base_q;
              wa_q    <= ra_q - 1'b1;
              bc_q    <= '0;
              state_q <= S_BITS;
            end else begin
              base_q <= base_q + CW'(WORD_BITS);
            end
          end
        end
        S_BITS: begin
          if (sh_q[0]) begin
            res_st_q <= STS_OK;
            res_id_q <= found_id[ID_W-1:0];
            state_q  <= S_RESP;
          end else begin
            sh_q <= sh_q >> 1;
            bc_q <= bc_q + 1'b1;
          end
        end
        S_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_st_q    <= res_st_q;
            out_id_q    <= res_id_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted request always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> state_q != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  // The shift-out only starts on a word that has a free bit in the window.
  a_bits_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BITS |-> sh_q != '0)
    else $error("bit shift-out running on a word without a free bit");

  // Only a successful allocate carries a nonzero id.
  a_id_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q != STS_OK) |-> out_id_q == '0)
    else $error("nonzero id on an error response");

  // The clearing sweep never overlaps a request.
  a_clear_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_busy |-> (state_q == S_IDLE && !mem_we))
    else $error("map access during the clearing sweep");

endmodule
